[rtl/core/pct_pkg.sv]
package pct_pkg;

	localparam int ACT_W = 16;
	localparam int W_W   = 24;
	localparam int F_W   = 16;

	localparam logic [ACT_W-1:0] ACT_ONE = 16'd32768;
	localparam logic [ACT_W-1:0] SIG_TOP = 16'd32757;

	localparam logic signed [W_W-1:0] W_MAX = 24'sh7FFFFF;
	localparam logic signed [W_W-1:0] W_MIN = 24'sh800000;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_TRAIN = 2'd1,
		MODE_TEST  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [0:0] {
		REG_RATE = 1'b0,
		REG_TOL  = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_RND,
		ST_MAG,
		ST_SIG,
		ST_HIT,
		ST_PMUL,
		ST_DMUL,
		ST_DRND,
		ST_RATE,
		ST_UPD
	} state_t;

	// request into the sigmoid unit: sign, saturation and |x| split at 0.5 steps
	typedef struct packed {
		logic        valid;
		logic        neg;
		logic        sat;
		logic [3:0]  seg;
		logic [13:0] frac;
	} sig_req_t;

	// sigmoid at seg * 0.5, Q1.15
	function automatic logic [ACT_W-1:0] sig_base(input logic [3:0] seg);
		logic [ACT_W-1:0] y;
		case (seg)
			4'd0:    y = 16'd16384;
			4'd1:    y = 16'd20397;
			4'd2:    y = 16'd23956;
			4'd3:    y = 16'd26790;
			4'd4:    y = 16'd28862;
			4'd5:    y = 16'd30282;
			4'd6:    y = 16'd31214;
			4'd7:    y = 16'd31807;
			4'd8:    y = 16'd32179;
			4'd9:    y = 16'd32408;
			4'd10:   y = 16'd32549;
			4'd11:   y = 16'd32635;
			4'd12:   y = 16'd32687;
			4'd13:   y = 16'd32719;
			4'd14:   y = 16'd32738;
			default: y = 16'd32750;
		endcase
		return y;
	endfunction

	// slope to the next table point
	function automatic logic [11:0] sig_delta(input logic [3:0] seg);
		logic [11:0] d;
		case (seg)
			4'd0:    d = 12'd4013;
			4'd1:    d = 12'd3559;
			4'd2:    d = 12'd2834;
			4'd3:    d = 12'd2072;
			4'd4:    d = 12'd1420;
			4'd5:    d = 12'd932;
			4'd6:    d = 12'd593;
			4'd7:    d = 12'd372;
			4'd8:    d = 12'd229;
			4'd9:    d = 12'd141;
			4'd10:   d = 12'd86;
			4'd11:   d = 12'd52;
			4'd12:   d = 12'd32;
			4'd13:   d = 12'd19;
			4'd14:   d = 12'd12;
			default: d = 12'd7;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/perceptron_train_classify.sv]
// Single sigmoid perceptron with delta-rule training.
// Input transaction: start is taken when busy is low. mode 0 writes weight_value
// at element_index (clears the hit count); modes 1 and 2 append feature_value to
// the point buffer, one per cycle, with busy staying low. The item with
// last_element set closes the point: busy rises and the block walks the n
// buffered features through the weight and feature memories (one read port each,
// one element per cycle, shared multiplier), then through the table sigmoid.
// done pulses for one cycle with activation, hit and hit_count after the walk,
// the rounding, the sigmoid and the hit check. A test point drops busy with
// done; a train point also rewrites every used weight in a second pass over the
// memories and keeps busy high until that pass ends.
// The receiver cannot stall: each result is valid only in its done cycle.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and
// belong in idle periods.
// Reset clears the control state, the feature count and the hit count, and loads
// the rate and tolerance defaults. Both memories come up undefined; there is no
// clearing pass, so weights must be loaded before a point is classified.
module perceptron_train_classify #(
	parameter int MAX_FEATURES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  logic [5:0]          element_index,
	input  logic [15:0]         feature_value,
	input  logic signed [23:0]  weight_value,
	input  logic [15:0]         target_value,
	input  logic                last_element,
	output logic                done,
	output logic [15:0]         activation,
	output logic                hit,
	output logic [15:0]         hit_count,
	input  logic                cfg_write,
	input  logic [0:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import pct_pkg::*;

	localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CNT_W = $clog2(MAX_FEATURES + 1);
	localparam int RD_W  = 31;
	localparam int MUL_W = RD_W + F_W + 1;
	localparam int ACC_W = MUL_W + CNT_W;
	localparam int XR_W  = ACC_W - 15;
	localparam int DW_W  = MUL_W - 31;

	state_t state_q, state_d;

	logic [15:0] rate_q;
	logic [15:0] tol_q;
	logic [15:0] hits_q;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] iss_q;
	logic             train_q;
	logic [15:0]      target_q;

	logic signed [W_W-1:0] wmem [MAX_FEATURES];
	logic [F_W-1:0]        fmem [MAX_FEATURES];

	logic                  v_s1, v_s2, v_s3;
	logic signed [W_W-1:0] w_s1, w_s2, w_s3;
	logic [F_W-1:0]        f_s1;
	logic [IDX_W-1:0]      addr_s1, addr_s2, addr_s3;
	logic signed [MUL_W-1:0] prod_s2;
	logic signed [DW_W-1:0]  dw_s3;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [XR_W-1:0]  xr_q;
	sig_req_t                sig_req_q;
	logic                    sig_valid;
	logic [ACT_W-1:0]        sig_act;
	logic [ACT_W-1:0]        act_q;
	logic [13:0]             p_q;
	logic signed [30:0]      pd_q;
	logic signed [15:0]      d_q;
	logic signed [RD_W-1:0]  rd_q;

	logic             done_q;
	logic [ACT_W-1:0] activation_q;
	logic             hit_q;

	// combinational
	logic                    accept;
	logic                    is_feat;
	logic                    load_ok;
	logic                    f_we;
	logic [CNT_W-1:0]        cnt_inc;
	logic                    issue;
	logic [IDX_W-1:0]        rd_addr;
	logic                    w_we;
	logic [IDX_W-1:0]        w_waddr;
	logic signed [W_W-1:0]   w_wdata;
	logic signed [RD_W-1:0]  mul_a;
	logic signed [F_W:0]     mul_b;
	logic signed [MUL_W-1:0] mul_p;
	logic signed [MUL_W-1:0] upd_rnd;
	logic signed [W_W:0]     nw;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [XR_W-1:0]  xabs;
	logic signed [16:0]      tdiff;
	logic [16:0]             adist;
	logic                    hit_now;
	logic [31:0]             pm;
	logic signed [30:0]      pd_a, pd_b, pd;
	logic signed [30:0]      pd_rnd;
	logic signed [RD_W-1:0]  rd_a, rd_b;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		is_feat = (mode == MODE_TRAIN) || (mode == MODE_TEST);
		load_ok = 32'(element_index) < MAX_FEATURES;
		f_we    = accept && is_feat && (cnt_q < CNT_W'(MAX_FEATURES));
		cnt_inc = f_we ? cnt_q + 1'b1 : cnt_q;

		issue   = ((state_q == ST_DOT) || (state_q == ST_UPD)) && (iss_q != n_q);
		rd_addr = iss_q[IDX_W-1:0];

		// shared element multiplier: weight in the dot pass, rate*delta in the update
		mul_a = (state_q == ST_UPD) ? rd_q : RD_W'(w_s1);
		mul_b = $signed({1'b0, f_s1});
		mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

		// round half away from zero, then >>> 31
		upd_rnd = prod_s2 + (prod_s2[MUL_W-1] ? MUL_W'(31'h3FFF_FFFF) : MUL_W'(31'h4000_0000));

		nw = {w_s3[W_W-1], w_s3} + (W_W+1)'(dw_s3);

		w_we    = 1'b0;
		w_waddr = IDX_W'(element_index);
		w_wdata = weight_value;
		if (accept && (mode == MODE_LOAD) && load_ok) begin
			w_we = 1'b1;
		end else if (v_s3) begin
			w_we    = 1'b1;
			w_waddr = addr_s3;
			if (nw[W_W] != nw[W_W-1])
				w_wdata = nw[W_W] ? W_MIN : W_MAX;
			else
				w_wdata = nw[W_W-1:0];
		end

		acc_rnd = acc_q + (acc_q[ACC_W-1] ? ACC_W'(15'h3FFF) : ACC_W'(15'h4000));
		xabs    = xr_q[XR_W-1] ? -xr_q : xr_q;

		tdiff   = $signed({1'b0, target_q}) - $signed({1'b0, act_q});
		adist   = tdiff[16] ? 17'(-tdiff) : 17'(tdiff);
		hit_now = adist < {1'b0, tol_q};

		pm = 32'(act_q) * 32'(ACT_ONE - act_q) + 32'd16384;

		pd_a   = $signed({17'b0, p_q});
		pd_b   = 31'(tdiff);
		pd     = pd_a * pd_b;
		pd_rnd = pd_q + (pd_q[30] ? 31'sh3FFF : 31'sh4000);

		rd_a = $signed({15'b0, rate_q});
		rd_b = RD_W'(d_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && is_feat && last_element) state_d = ST_DOT;
			ST_DOT:  if (!issue && !v_s1 && !v_s2) state_d = ST_RND;
			ST_RND:  state_d = ST_MAG;
			ST_MAG:  state_d = ST_SIG;
			ST_SIG:  if (sig_valid) state_d = ST_HIT;
			ST_HIT:  state_d = train_q ? ST_PMUL : ST_IDLE;
			ST_PMUL: state_d = ST_DMUL;
			ST_DMUL: state_d = ST_DRND;
			ST_DRND: state_d = ST_RATE;
			ST_RATE: state_d = ST_UPD;
			ST_UPD:  if (!issue && !v_s1 && !v_s2 && !v_s3) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= 16'd655;
			tol_q     <= 16'd16384;
			hits_q    <= '0;
			cnt_q     <= '0;
			iss_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			sig_req_q <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_RATE: rate_q <= cfg_data;
					REG_TOL:  tol_q  <= cfg_data;
					default:  ;
				endcase
			end

			if (accept && (mode == MODE_LOAD))
				hits_q <= '0;
			else if ((state_q == ST_HIT) && hit_now && (hits_q != 16'hFFFF))
				hits_q <= hits_q + 16'd1;

			if (accept && is_feat)
				cnt_q <= last_element ? '0 : cnt_inc;

			if (state_q == ST_IDLE || state_q == ST_RATE)
				iss_q <= '0;
			else if (issue)
				iss_q <= iss_q + 1'b1;

			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (state_q == ST_UPD);

			sig_req_q.valid <= (state_q == ST_MAG);
			if (state_q == ST_MAG) begin
				sig_req_q.neg  <= xr_q[XR_W-1];
				sig_req_q.sat  <= |xabs[XR_W-1:18];
				sig_req_q.seg  <= xabs[17:14];
				sig_req_q.frac <= xabs[13:0];
			end
			done_q          <= (state_q == ST_HIT);
		end
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (w_we)
			wmem[w_waddr] <= w_wdata;
		if (f_we)
			fmem[cnt_q[IDX_W-1:0]] <= feature_value;
		w_s1    <= wmem[rd_addr];
		f_s1    <= fmem[rd_addr];
		addr_s1 <= rd_addr;
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s2 <= mul_p;
		w_s2    <= w_s1;
		addr_s2 <= addr_s1;

		dw_s3   <= upd_rnd[MUL_W-1:31];
		w_s3    <= w_s2;
		addr_s3 <= addr_s2;

		if (accept && is_feat && last_element) begin
			n_q      <= cnt_inc;
			train_q  <= (mode == MODE_TRAIN);
			target_q <= target_value;
			acc_q    <= '0;
		end else if ((state_q == ST_DOT) && v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end

		if (state_q == ST_RND)
			xr_q <= acc_rnd[ACC_W-1:15];

		if ((state_q == ST_SIG) && sig_valid)
			act_q <= sig_act;

		if (state_q == ST_HIT) begin
			activation_q <= act_q;
			hit_q        <= hit_now;
		end

		if (state_q == ST_PMUL)
			p_q <= pm[28:15];
		if (state_q == ST_DMUL)
			pd_q <= pd;
		if (state_q == ST_DRND)
			d_q <= pd_rnd[30:15];
		if (state_q == ST_RATE)
			rd_q <= rd_a * rd_b;
	end

	pct_sigmoid u_sigmoid (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (sig_req_q),
		.act_valid (sig_valid),
		.act       (sig_act)
	);

	assign done       = done_q;
	assign activation = activation_q;
	assign hit        = hit_q;
	assign hit_count  = hits_q;

endmodule

[rtl/core/pct_sigmoid.sv]
module pct_sigmoid (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pct_pkg::sig_req_t            req,
	output logic                         act_valid,
	output logic [pct_pkg::ACT_W-1:0]    act
);
	import pct_pkg::*;

	logic        v_s1;
	logic        neg_s1;
	logic        sat_s1;
	logic [3:0]  seg_s1;
	logic [25:0] interp_s1;

	logic             v_s2;
	logic [ACT_W-1:0] act_s2;

	logic [25:0]      interp_rnd;
	logic [ACT_W-1:0] y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1    <= req.neg;
		sat_s1    <= req.sat;
		seg_s1    <= req.seg;
		interp_s1 <= 26'(sig_delta(req.seg)) * 26'(req.frac);
		act_s2    <= act_s2;
		if (v_s1)
			act_s2 <= neg_s1 ? (ACT_ONE - y) : y;
	end

	always_comb begin
		interp_rnd = interp_s1 + 26'd8192;
		if (sat_s1)
			y = SIG_TOP;
		else
			y = sig_base(seg_s1) + ACT_W'(interp_rnd[25:14]);
	end

	assign act_valid = v_s2;
	assign act       = act_s2;

endmodule

[rtl/core/pct_checker.sv]
module pct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  mode,
	input logic        last_element,
	input logic        done,
	input logic [15:0] activation,
	input logic        hit,
	input logic [15:0] hit_count
);
	import pct_pkg::*;

	// results are never adjacent
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// a closing feature transaction starts the point walk
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_element && (mode == MODE_TRAIN || mode == MODE_TEST))
		|=> busy)
		else $error("busy did not rise after the last feature");

	// a weight load never produces a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_LOAD)) |=> !done)
		else $error("result after weight load");

	// a hit always leaves a nonzero count
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (hit_count != 16'd0))
		else $error("hit reported with zero hit count");

	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (activation <= ACT_ONE))
		else $error("activation above 1.0");

endmodule

bind perceptron_train_classify pct_checker u_pct_checker (.*);

[bench/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pct_pkg::*;

	localparam int NFEAT      = 64;
	localparam int SETTLE     = 2 * NFEAT + 40;
	localparam int MAX_WAIT   = 2000;
	localparam int PHASE_ITEMS = 200;
	localparam int HIT_POINTS = 40;

	typedef struct {
		logic [15:0] act;
		logic        hit;
		logic [15:0] count;
	} neuron_out_t;

	class neuron_tracker;
		int errors;
		logic [15:0] rate;
		logic [15:0] tol;
		int weights[NFEAT];
		int feats[NFEAT];
		int fill;
		int hits;
		int sig_pts[17];
		neuron_out_t pending[$];

		function new();
			errors = 0;
			rate = 16'd655;
			tol = 16'd16384;
			fill = 0;
			hits = 0;
			for (int i = 0; i < NFEAT; i++) begin
				weights[i] = 0;
				feats[i] = 0;
			end
			sig_pts = '{16384, 20397, 23956, 26790, 28862, 30282, 31214, 31807, 32179,
				32408, 32549, 32635, 32687, 32719, 32738, 32750, 32757};
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 20)
				$display("%0t ERROR: %s", $time, msg);
		endtask

		function longint round_half_away(longint v, int s);
			longint m;
			m = (v < 0) ? -v : v;
			m = (m + (longint'(1) << (s - 1))) >>> s;
			return (v < 0) ? -m : m;
		endfunction

		function int squash(longint x);
			longint mag;
			int seg, frac, y;
			mag = (x < 0) ? -x : x;
			if (mag >= (longint'(8) << 15)) begin
				y = sig_pts[16];
			end else begin
				seg = int'(mag >>> 14);
				frac = int'(mag & 16383);
				y = sig_pts[seg] + (((sig_pts[seg + 1] - sig_pts[seg]) * frac + 8192) >>> 14);
			end
			return (x < 0) ? 32768 - y : y;
		endfunction

		function void accept_item(mode_t m, logic [5:0] idx, logic [15:0] f,
				logic signed [23:0] w, logic [15:0] tgt, logic last);
			longint sum, p, d, dw, nw;
			int n, act, diff, i;
			bit h;
			neuron_out_t o;
			if (m == MODE_LOAD) begin
				weights[idx] = int'(w);
				hits = 0;
				return;
			end
			if (m == MODE_NONE)
				return;
			if (fill < NFEAT) begin
				feats[fill] = int'(f);
				fill++;
			end
			if (!last)
				return;
			n = fill;
			fill = 0;
			sum = 0;
			for (i = 0; i < n; i++)
				sum += longint'(weights[i]) * feats[i];
			act = squash(round_half_away(sum, 15));
			diff = act - int'(tgt);
			if (diff < 0)
				diff = -diff;
			h = diff < int'(tol);
			if (h && hits < 65535)
				hits++;
			if (m == MODE_TRAIN) begin
				// every weight moves with the activation from before the update
				p = (longint'(act) * (32768 - act) + 16384) >>> 15;
				d = round_half_away(p * (int'(tgt) - act), 15);
				for (i = 0; i < n; i++) begin
					dw = round_half_away(longint'(rate) * d * feats[i], 31);
					nw = weights[i] + dw;
					if (nw > W_MAX)
						nw = W_MAX;
					if (nw < W_MIN)
						nw = W_MIN;
					weights[i] = int'(nw);
				end
			end
			o.act = 16'(act);
			o.hit = h;
			o.count = 16'(hits);
			pending.push_back(o);
		endfunction

		task compare_output(logic [15:0] a, logic h, logic [15:0] c);
			neuron_out_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result: activation %0d hit %0b count %0d", a, h, c));
				return;
			end
			e = pending.pop_front();
			if (a !== e.act)
				report($sformatf("activation %0d, expected %0d", a, e.act));
			if (h !== e.hit)
				report($sformatf("hit %0b, expected %0b", h, e.hit));
			if (c !== e.count)
				report($sformatf("hit_count %0d, expected %0d", c, e.count));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	mode_t              mode;
	logic [5:0]         element_index;
	logic [15:0]        feature_value;
	logic signed [23:0] weight_value;
	logic [15:0]        target_value;
	logic               last_element;
	logic               done;
	logic [15:0]        activation;
	logic               hit;
	logic [15:0]        hit_count;
	logic               cfg_write;
	cfg_reg_t           cfg_index;
	logic [15:0]        cfg_data;

	neuron_tracker model;
	int items_done;
	bit gaps_on;

	perceptron_train_classify uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.element_index(element_index),
		.feature_value(feature_value),
		.weight_value(weight_value),
		.target_value(target_value),
		.last_element(last_element),
		.done(done),
		.activation(activation),
		.hit(hit),
		.hit_count(hit_count),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			model.compare_output(activation, hit, hit_count);
	end

	// start stays high on return so that back-to-back transactions need no toggle
	task automatic push_item(mode_t m, logic [5:0] idx, logic [15:0] f,
			logic signed [23:0] w, logic [15:0] tgt, logic last);
		start <= 1'b1;
		mode <= m;
		element_index <= idx;
		feature_value <= f;
		weight_value <= w;
		target_value <= tgt;
		last_element <= last;
		do
			@(posedge clk);
		while (busy);
		model.accept_item(m, idx, f, w, tgt, last);
		if (m != MODE_NONE)
			items_done++;
	endtask

	task automatic gap();
		int r, n;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			n = 0;
		else if (r < 93)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic settle();
		int k;
		start <= 1'b0;
		k = 0;
		while (model.pending.size() != 0 && k < MAX_WAIT) begin
			@(posedge clk);
			k++;
		end
		if (model.pending.size() != 0) begin
			model.report($sformatf("%0d results never arrived", model.pending.size()));
			model.pending.delete();
		end
		// a train point keeps rewriting weights after its result
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] rate, logic [15:0] tol);
		cfg_write <= 1'b1;
		cfg_index <= REG_RATE;
		cfg_data <= rate;
		@(posedge clk);
		cfg_index <= REG_TOL;
		cfg_data <= tol;
		@(posedge clk);
		cfg_write <= 1'b0;
		model.rate = rate;
		model.tol = tol;
	endtask

	function automatic logic [15:0] rand_q15();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 16'd0;
		if (r < 16)
			return ACT_ONE;
		return 16'($urandom_range(0, 32768));
	endfunction

	function automatic logic signed [23:0] rand_weight();
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 4)
			return W_MAX;
		if (r < 8)
			return W_MIN;
		if (r < 12)
			return '0;
		if (r < 80) begin
			v = int'($urandom_range(0, 131072)) - 65536;
			return v[23:0];
		end
		return 24'($urandom);
	endfunction

	task automatic side_item(int r);
		if (r < 3)
			push_item(MODE_LOAD, 6'($urandom), 16'($urandom), rand_weight(),
				16'($urandom), 1'($urandom));
		else if (r < 5)
			push_item(MODE_NONE, 6'($urandom), 16'($urandom), 24'($urandom),
				16'($urandom), 1'($urandom));
		if (r < 5)
			gap();
	endtask

	task automatic random_point();
		int n, r, k;
		mode_t pm, im;
		bit mixed;
		logic [15:0] tgt;
		r = $urandom_range(0, 99);
		if (r < 70)
			n = $urandom_range(1, 8);
		else if (r < 95)
			n = $urandom_range(9, NFEAT);
		else
			n = $urandom_range(NFEAT + 1, NFEAT + 6);
		pm = ($urandom_range(0, 1) != 0) ? MODE_TRAIN : MODE_TEST;
		mixed = $urandom_range(0, 9) == 0;
		tgt = rand_q15();
		gaps_on = $urandom_range(0, 4) != 0;
		for (k = 0; k < n; k++) begin
			side_item($urandom_range(0, 99));
			im = pm;
			if (mixed && $urandom_range(0, 1) != 0)
				im = (pm == MODE_TRAIN) ? MODE_TEST : MODE_TRAIN;
			push_item(im, 6'($urandom), rand_q15(), 24'($urandom),
				(k == n - 1) ? tgt : rand_q15(), k == n - 1);
			gap();
		end
		side_item($urandom_range(0, 40));
	endtask

	task automatic random_phase(int count);
		int goal;
		goal = items_done + count;
		while (items_done < goal)
			random_point();
	endtask

	initial begin
		int k, ph;
		model = new();
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_LOAD;
		element_index = '0;
		feature_value = '0;
		weight_value = '0;
		target_value = '0;
		last_element = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_RATE;
		cfg_data = '0;
		items_done = 0;
		gaps_on = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// weight memory has no reset: define every entry before the first point
		for (k = 0; k < NFEAT; k++)
			push_item(MODE_LOAD, 6'(k), 16'($urandom),
				(k == 0) ? W_MAX : (k == 1) ? W_MIN : rand_weight(),
				16'($urandom), 1'($urandom));

		// sigmoid saturation at both ends
		push_item(MODE_TEST, 6'd0, ACT_ONE, '0, ACT_ONE, 1'b1);
		push_item(MODE_TEST, 6'd0, 16'd0, '0, 16'd0, 1'b0);
		push_item(MODE_TEST, 6'd0, ACT_ONE, '0, 16'd0, 1'b1);

		// near-zero sum with weights pinned at the limits: updates clamp
		push_item(MODE_TEST, 6'd0, ACT_ONE, '0, 16'd0, 1'b0);
		push_item(MODE_TRAIN, 6'd0, ACT_ONE, '0, ACT_ONE, 1'b1);
		push_item(MODE_LOAD, 6'd1, '0, W_MIN, '0, 1'b0);
		push_item(MODE_TRAIN, 6'd0, ACT_ONE, '0, 16'd0, 1'b0);
		push_item(MODE_TRAIN, 6'd0, ACT_ONE, '0, 16'd0, 1'b1);

		// load and ignored command in the middle of a point
		push_item(MODE_TRAIN, 6'd5, 16'd12345, 24'h5A5A5A, 16'd100, 1'b0);
		push_item(MODE_LOAD, 6'd63, 16'hFFFF, rand_weight(), 16'hFFFF, 1'b1);
		push_item(MODE_NONE, 6'd63, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1);
		push_item(MODE_TEST, 6'd63, 16'd20000, 24'h000000, 16'd30000, 1'b1);

		// more features than the buffer holds
		for (k = 0; k < NFEAT + 6; k++)
			push_item(MODE_TRAIN, 6'(k), rand_q15(), 24'($urandom), 16'd16384,
				k == NFEAT + 5);

		for (ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: set_regs(16'hFFFF, 16'd0);
				1: set_regs(16'd0, ACT_ONE);
				2: set_regs(16'd655, 16'd16384);
				default: set_regs(16'($urandom), 16'($urandom_range(0, 32768)));
			endcase
			random_phase(PHASE_ITEMS);
		end

		// tolerance of 1.0 makes every point a hit
		settle();
		set_regs(16'($urandom), ACT_ONE);
		gaps_on = 1'b0;
		push_item(MODE_LOAD, 6'd0, '0, rand_weight(), '0, 1'b0);
		for (k = 0; k < HIT_POINTS; k++)
			push_item(MODE_TEST, 6'($urandom), rand_q15(), 24'($urandom), rand_q15(), 1'b1);
		push_item(MODE_LOAD, 6'd0, '0, rand_weight(), '0, 1'b0);
		push_item(MODE_TRAIN, 6'd0, rand_q15(), '0, rand_q15(), 1'b1);
		push_item(MODE_TEST, 6'd0, rand_q15(), '0, rand_q15(), 1'b1);

		settle();
		if (model.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[files.f]
rtl/core/pct_pkg.sv
rtl/core/pct_sigmoid.sv
rtl/core/perceptron_train_classify.sv
rtl/core/pct_checker.sv
bench/testbench.sv
